[src/b32uc_pkg.sv]
`default_nettype none

package b32uc_pkg;

    localparam int NUM_CHARS  = 26;
    localparam int COUNT_SAT  = 27;
    localparam int GROUP_W    = 5;
    localparam int VALUE_W    = 128;
    localparam int SHIFT_W    = VALUE_W + 2;
    localparam int CNT_W      = 5;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [0:0] CMD_ENCODE = 1'b0;
    localparam logic [0:0] CMD_DECODE = 1'b1;

    localparam logic [7:0] FIRST_MIN = 8'h30;
    localparam logic [7:0] FIRST_MAX = 8'h37;

    localparam logic [7:0] ALPHABET [32] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66,
        8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6d, 8'h6e, 8'h70, 8'h71,
        8'h72, 8'h73, 8'h74, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7a
    };

    typedef struct packed {
        logic [0:0]  command;
        logic [63:0] value_high;
        logic [63:0] value_low;
        logic [7:0]  char_code;
        logic        last_char;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  out_char;
        logic [63:0] result_high;
        logic [63:0] result_low;
        logic        ok;
        logic        last_out;
    } t_out_item;

    // One unit of back-end work: an encode value or a finished decode result
    typedef struct packed {
        logic               is_dec;
        logic               ok;
        logic [VALUE_W-1:0] data;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    typedef struct packed {
        logic               valid;
        logic [GROUP_W-1:0] value;
    } t_digit;

    function automatic t_digit char_to_digit(input logic [7:0] c);
        t_digit d;
        d = '0;
        for (int k = 0; k < 32; k++) begin
            if (ALPHABET[k] == c) begin
                d.valid = 1'b1;
                d.value = GROUP_W'(k);
            end
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[src/b32uc_if.sv]
`default_nettype none

interface b32uc_in_if;
    logic                 valid;
    logic                 ready;
    b32uc_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface b32uc_out_if;
    logic                 valid;
    logic                 ready;
    b32uc_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[src/b32uc_front.sv]
`default_nettype none

module b32uc_front (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    b32uc_in_if.sink              i_in,
    input  wire b32uc_pkg::t_qstat i_qstat,
    output logic                  o_push,
    output b32uc_pkg::t_job       o_job
);
    import b32uc_pkg::*;

    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_bad, n_bad;

    t_digit             dig;
    logic               accept;
    logic               first_bad;
    logic               good;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        dig       = char_to_digit(i_in.data.char_code);
        first_bad = (r_cnt == '0) &&
                    (i_in.data.char_code < FIRST_MIN || i_in.data.char_code > FIRST_MAX);
        n_bad     = r_bad || first_bad || !dig.valid;
        n_acc     = {r_acc[VALUE_W-GROUP_W-1:0], dig.valid ? dig.value : GROUP_W'(0)};
        n_cnt     = (r_cnt < CNT_W'(COUNT_SAT)) ? r_cnt + CNT_W'(1) : r_cnt;
        good      = !n_bad && (n_cnt == CNT_W'(NUM_CHARS));

        o_push = accept && (i_in.data.command == CMD_ENCODE || i_in.data.last_char);
        if (i_in.data.command == CMD_ENCODE) begin
            o_job.is_dec = 1'b0;
            o_job.ok     = 1'b1;
            o_job.data   = {i_in.data.value_high, i_in.data.value_low};
        end else begin
            o_job.is_dec = 1'b1;
            o_job.ok     = good;
            o_job.data   = good ? n_acc : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_cnt <= '0;
            r_bad <= 1'b0;
        end else if (accept && i_in.data.command == CMD_DECODE) begin
            // end of run: drop the decode state
            if (i_in.data.last_char) begin
                r_acc <= '0;
                r_cnt <= '0;
                r_bad <= 1'b0;
            end else begin
                r_acc <= n_acc;
                r_cnt <= n_cnt;
                r_bad <= n_bad;
            end
        end
    end

endmodule

`default_nettype wire

[src/b32uc_queue.sv]
`default_nettype none

module b32uc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire b32uc_pkg::t_job  i_job,
    input  wire logic             i_pop,
    output b32uc_pkg::t_qstat     o_qstat,
    output b32uc_pkg::t_job       o_head
);
    import b32uc_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign o_qstat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_qstat.empty = (r_count == '0);
    assign o_head        = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

[src/b32uc_back.sv]
`default_nettype none

module b32uc_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire b32uc_pkg::t_qstat i_qstat,
    input  wire b32uc_pkg::t_job   i_head,
    output logic                   o_pop,
    b32uc_out_if.source            o_out
);
    import b32uc_pkg::*;

    logic               r_busy;
    logic               r_is_dec;
    logic               r_ok;
    logic [SHIFT_W-1:0] r_shift;
    logic [CNT_W-1:0]   r_cnt;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               advance;
    logic               finishing;
    t_out_item          n_out;

    assign advance   = r_busy && (!r_out_valid || o_out.ready);
    assign finishing = r_is_dec || (r_cnt == CNT_W'(NUM_CHARS - 1));
    assign o_pop     = !i_qstat.empty && (!r_busy || (advance && finishing));

    always_comb begin
        if (r_is_dec) begin
            n_out.out_char    = 8'h00;
            n_out.result_high = r_shift[VALUE_W-1:64];
            n_out.result_low  = r_shift[63:0];
        end else begin
            n_out.out_char    = ALPHABET[r_shift[SHIFT_W-1:SHIFT_W-GROUP_W]];
            n_out.result_high = '0;
            n_out.result_low  = '0;
        end
        n_out.ok       = r_ok;
        n_out.last_out = finishing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (advance && finishing) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_is_dec <= i_head.is_dec;
            r_ok     <= i_head.ok;
            r_shift  <= {2'b00, i_head.data};
            r_cnt    <= '0;
        end else if (advance) begin
            // next five-bit group moves to the top
            r_shift <= {r_shift[SHIFT_W-GROUP_W-1:0], GROUP_W'(0)};
            r_cnt   <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

`default_nettype wire

[src/base32_uuid_codec.sv]
// A word is queued, loaded into the shift register, then registered at the output.
// Decode takes one character word per cycle unless the queue is full; only the last one yields a result.
// Encode emits 26 character words, one per cycle while the output is ready, from the output serializer;
// a two-entry job queue lets input continue until it fills behind the serializer.
// Reset (synchronous, active low) clears the decode state, the queue and output valid.
`default_nettype none

module base32_uuid_codec (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    b32uc_in_if.sink    i_in,
    b32uc_out_if.source o_out
);
    import b32uc_pkg::*;

    t_qstat qstat;
    t_job   push_job;
    t_job   head_job;
    logic   push;
    logic   pop;

    b32uc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_job   (push_job)
    );

    b32uc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_qstat (qstat),
        .o_head  (head_job)
    );

    b32uc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_head  (head_job),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire
